// File: hdl/mahd_pkg.sv
// Package for the MPEG audio header decoder: item types, field codes and lookup tables.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package mahd_pkg;

  localparam int HEADER_W = 32;

  // Reserved layer code after mapping.
  localparam logic [1:0] LAYER_RSV = 2'd0;
  // Version codes.
  localparam logic [1:0] VER_MPEG1  = 2'd1;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG25 = 2'd3;
  // Channel mode for single channel.
  localparam logic [1:0] MODE_MONO = 2'd3;
  // Sample rate index that holds no rate.
  localparam logic [1:0] SR_RSV = 2'd3;

  localparam logic [10:0] SAMPLES_V1    = 11'd1152;
  localparam logic [10:0] SAMPLES_OTHER = 11'd576;

  // Frame length numerator width and reciprocal for the divide by 49.
  localparam int LEN_NUM_W   = 17;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = LEN_NUM_W + RECIP_W;
  localparam int DIV49_SHIFT = 23;
  localparam logic [RECIP_W-1:0] DIV49_RECIP = 18'd171197;

  // How the back end turns the numerator into a byte count.
  typedef enum logic [1:0] {
    LEN_ZERO,
    LEN_DIRECT,
    LEN_HALF,
    LEN_DIV49
  } mahd_len_t;

  // One classified header travelling from the front end to the back end.
  typedef struct packed {
    logic                 valid_res;
    logic [1:0]           version;
    logic [1:0]           layer;
    logic [8:0]           bitrate_kbps;
    logic [15:0]          samplerate_hz;
    logic [1:0]           channels;
    logic [10:0]          samples_per_frame;
    logic [4:0]           flag_bits;
    logic [1:0]           channel_mode;
    logic [1:0]           mode_extension;
    logic [1:0]           emphasis;
    logic                 pad;
    mahd_len_t            len_mode;
    logic [LEN_NUM_W-1:0] len_num;
  } mahd_item_t;

  // Bitrate tables: first row MPEG-1, second row MPEG-2 and MPEG-2.5; then layer 1..3.
  localparam logic [8:0] KBPS_TAB [2][3][16] = '{
    '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
    },
    '{
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    }
  };

  localparam logic [15:0] HZ_TAB [3][4] = '{
    '{16'd44100, 16'd48000, 16'd32000, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0},
    '{16'd11025, 16'd12000, 16'd8000,  16'd0}
  };

  function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [1:0] lay,
                                             input logic [3:0] idx);
    logic       row;
    logic [1:0] col;
    row = (ver != VER_MPEG1);
    col = lay - 2'd1;
    if (lay == LAYER_RSV) begin
      return 9'd0;
    end
    return KBPS_TAB[row][col][idx];
  endfunction

  function automatic logic [15:0] hz_lookup(input logic [1:0] ver, input logic [1:0] sr);
    logic [15:0] hz;
    case (ver)
      VER_MPEG1:  hz = HZ_TAB[0][sr];
      VER_MPEG2:  hz = HZ_TAB[1][sr];
      VER_MPEG25: hz = HZ_TAB[2][sr];
      default:    hz = 16'd0;
    endcase
    return hz;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mpeg_audio_header_decoder_top.sv
// Top level of the MPEG audio header decoder: front end, queue and back end.
// Depends on mahd_pkg, mahd_front, mahd_queue and mahd_back.
//
//   channel   direction  handshake            payload
//   in_*      input      in_valid / in_stall  in_header_word (32 bits)
//   out_*     output     out_valid/out_stall  decoded header fields, frame_bytes
//
// One header word is taken per clock, and one result leaves per clock while out_stall
// stays low. The input transfer loads the front register; the item then passes through the
// queue slot, the reciprocal multiply for the divide by 49 and the result register, in
// that order. During an output stall the front end keeps taking headers until the queue
// and the front register are full, QUEUE_DEPTH + 3 items from empty. Reset empties all
// stages.
`timescale 1ns / 1ps
`default_nettype none

module mpeg_audio_header_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Header words in.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_header_word,
  // Decoded headers out.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_valid_res,
  output logic [1:0]       out_version,
  output logic [1:0]       out_layer,
  output logic [8:0]       out_bitrate_kbps,
  output logic [15:0]      out_samplerate_hz,
  output logic [1:0]       out_channels,
  output logic [10:0]      out_samples_per_frame,
  output logic [11:0]      out_frame_bytes,
  output logic [4:0]       out_flag_bits,
  output logic [1:0]       out_channel_mode,
  output logic [1:0]       out_mode_extension,
  output logic [1:0]       out_emphasis
);
  import mahd_pkg::*;

  logic       front_valid, front_ready;
  mahd_item_t front_item;
  logic       queue_valid, back_ready;
  mahd_item_t queue_item;
  mahd_item_t res_item;

  // The front end unpacks the word and turns the frame length into a numerator plus a
  // divide mode, so the back end only multiplies, selects and adds the padding byte.
  mahd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .hdr_valid_i  (in_valid),
    .hdr_stall_o  (in_stall),
    .hdr_word_i   (in_header_word),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  // The queue decouples the two sides so that an output stall does not reach the input
  // until the queue is full.
  mahd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_item_i  (front_item),
    .rd_valid_o (queue_valid),
    .rd_ready_i (back_ready),
    .rd_item_o  (queue_item)
  );

  // The back end holds the multiply stage and the output register.
  mahd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid_i      (queue_valid),
    .item_ready_o      (back_ready),
    .item_i            (queue_item),
    .res_valid_o       (out_valid),
    .res_stall_i       (out_stall),
    .res_item_o        (res_item),
    .res_frame_bytes_o (out_frame_bytes)
  );

  assign out_valid_res         = res_item.valid_res;
  assign out_version           = res_item.version;
  assign out_layer             = res_item.layer;
  assign out_bitrate_kbps      = res_item.bitrate_kbps;
  assign out_samplerate_hz     = res_item.samplerate_hz;
  assign out_channels          = res_item.channels;
  assign out_samples_per_frame = res_item.samples_per_frame;
  assign out_flag_bits         = res_item.flag_bits;
  assign out_channel_mode      = res_item.channel_mode;
  assign out_mode_extension    = res_item.mode_extension;
  assign out_emphasis          = res_item.emphasis;

endmodule

`default_nettype wire

// File: hdl/mahd_front.sv
// Front end of the MPEG audio header decoder: unpacks a header word, looks up the rates
// and classifies the frame length work. Depends on mahd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mahd_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       hdr_valid_i,
  output logic                            hdr_stall_o,
  input  wire logic [31:0]                hdr_word_i,
  output logic                            item_valid_o,
  input  wire logic                       item_ready_i,
  output mahd_pkg::mahd_item_t            item_o
);
  import mahd_pkg::*;

  logic       valid_r, valid_nxt;
  mahd_item_t item_r;
  mahd_item_t item_nxt;
  logic       take;

  logic [1:0]  ver;
  logic [1:0]  lay;
  logic [1:0]  sr_idx;
  logic [8:0]  kbps;
  logic [15:0] hz;
  logic [LEN_NUM_W-1:0] kx;
  logic [LEN_NUM_W-1:0] num_base;

  assign hdr_stall_o = valid_r && !item_ready_i;
  assign take        = hdr_valid_i && !hdr_stall_o;

  always_comb begin
    if (!hdr_word_i[20]) begin
      ver = VER_MPEG25;
    end else if (hdr_word_i[19]) begin
      ver = VER_MPEG1;
    end else begin
      ver = VER_MPEG2;
    end
    // Layer bits 11, 10, 01 map to 1, 2, 3; the two's complement does exactly that.
    lay    = 2'd0 - hdr_word_i[18:17];
    sr_idx = hdr_word_i[11:10];
    kbps   = kbps_lookup(ver, lay, hdr_word_i[15:12]);
    hz     = hz_lookup(ver, sr_idx);
    kx     = LEN_NUM_W'(kbps);

    // Bytes per frame reduce to kbps * 160/49, 3 or 9/2, doubled for MPEG-2.5.
    case (sr_idx)
      2'd0:    num_base = (kx << 7) + (kx << 5);
      2'd1:    num_base = (kx << 1) + kx;
      2'd2:    num_base = (kx << 3) + kx;
      default: num_base = '0;
    endcase

    item_nxt.valid_res         = (&hdr_word_i[31:21]) && (lay != LAYER_RSV) &&
                                 (kbps != 9'd0) && (hz != 16'd0);
    item_nxt.version           = ver;
    item_nxt.layer             = lay;
    item_nxt.bitrate_kbps      = kbps;
    item_nxt.samplerate_hz     = hz;
    item_nxt.channels          = (hdr_word_i[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
    item_nxt.samples_per_frame = (ver == VER_MPEG1) ? SAMPLES_V1 : SAMPLES_OTHER;
    item_nxt.flag_bits         = {hdr_word_i[2], hdr_word_i[3], hdr_word_i[8],
                                  hdr_word_i[9], !hdr_word_i[16]};
    item_nxt.channel_mode      = hdr_word_i[7:6];
    item_nxt.mode_extension    = hdr_word_i[5:4];
    item_nxt.emphasis          = hdr_word_i[1:0];
    item_nxt.pad               = hdr_word_i[9];
    item_nxt.len_num           = (ver == VER_MPEG25) ? (num_base << 1) : num_base;
    case (sr_idx)
      2'd0:    item_nxt.len_mode = LEN_DIV49;
      2'd1:    item_nxt.len_mode = LEN_DIRECT;
      2'd2:    item_nxt.len_mode = LEN_HALF;
      default: item_nxt.len_mode = LEN_ZERO;
    endcase

    if (take) begin
      valid_nxt = 1'b1;
    end else if (item_ready_i) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid_o = valid_r;
  assign item_o       = item_r;

endmodule

`default_nettype wire

// File: hdl/mahd_queue.sv
// Short queue between the front and back ends of the MPEG audio header decoder.
// Holds classified items in flip-flops. Depends on mahd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mahd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_valid_i,
  output logic                      wr_ready_o,
  input  wire mahd_pkg::mahd_item_t wr_item_i,
  output logic                      rd_valid_o,
  input  wire logic                 rd_ready_i,
  output mahd_pkg::mahd_item_t      rd_item_o
);
  import mahd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mahd_item_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign wr_ready_o = (count_r != FULL_CNT);
  assign rd_valid_o = (count_r != '0);
  assign rd_item_o  = slot_r[rd_ptr_r];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

// File: hdl/mahd_back.sv
// Back end of the MPEG audio header decoder: frame length arithmetic and the result register.
// Depends on mahd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mahd_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_valid_i,
  output logic                      item_ready_o,
  input  wire mahd_pkg::mahd_item_t item_i,
  output logic                      res_valid_o,
  input  wire logic                 res_stall_i,
  output mahd_pkg::mahd_item_t      res_item_o,
  output logic [11:0]               res_frame_bytes_o
);
  import mahd_pkg::*;

  // Multiply stage.
  logic              mul_valid_r, mul_valid_nxt;
  mahd_item_t        mul_item_r;
  logic [PROD_W-1:0] mul_prod_r;
  logic              mul_ready;
  logic              mul_take;

  // Result stage.
  logic              res_valid_r, res_valid_nxt;
  mahd_item_t        res_item_r;
  logic [11:0]       res_bytes_r, res_bytes_nxt;
  logic              res_ready;
  logic [11:0]       len_base;

  assign res_ready    = !res_valid_r || !res_stall_i;
  assign mul_ready    = !mul_valid_r || res_ready;
  assign item_ready_o = mul_ready;
  assign mul_take     = item_valid_i && mul_ready;

  always_comb begin
    if (mul_take) begin
      mul_valid_nxt = 1'b1;
    end else if (res_ready) begin
      mul_valid_nxt = 1'b0;
    end else begin
      mul_valid_nxt = mul_valid_r;
    end

    if (mul_valid_r && res_ready) begin
      res_valid_nxt = 1'b1;
    end else if (!res_stall_i) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end

    case (mul_item_r.len_mode)
      LEN_DIRECT: len_base = mul_item_r.len_num[11:0];
      LEN_HALF:   len_base = mul_item_r.len_num[12:1];
      LEN_DIV49:  len_base = mul_prod_r[DIV49_SHIFT +: 12];
      default:    len_base = 12'd0;
    endcase
    if (mul_item_r.len_mode == LEN_ZERO) begin
      res_bytes_nxt = 12'd0;
    end else begin
      res_bytes_nxt = len_base + {11'd0, mul_item_r.pad};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= mul_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_take) begin
      mul_item_r <= item_i;
      mul_prod_r <= PROD_W'(item_i.len_num) * PROD_W'(DIV49_RECIP);
    end
    if (mul_valid_r && res_ready) begin
      res_item_r  <= mul_item_r;
      res_bytes_r <= res_bytes_nxt;
    end
  end

  assign res_valid_o       = res_valid_r;
  assign res_item_o        = res_item_r;
  assign res_frame_bytes_o = res_bytes_r;

  a_ok_has_rates: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_item_r.valid_res |->
      res_item_r.bitrate_kbps != 9'd0 && res_item_r.samplerate_hz != 16'd0 &&
      res_item_r.layer != LAYER_RSV)
    else $error("header marked valid without rates");

  a_no_rate_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_item_r.samplerate_hz == 16'd0 |-> res_bytes_r == 12'd0)
    else $error("frame length nonzero without sample rate");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    mul_valid_r && res_ready |=> res_valid_r)
    else $error("multiply stage result lost");

endmodule

`default_nettype wire
